// ----- rtl/core/ncdf_pkg.sv -----
package ncdf_pkg;

  // Q.30 helpers
  localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
  localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

  // coefficient magnitudes, rounded to nearest
  localparam logic [63:0] A1_MAG = (64'd254829592 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
  localparam logic [63:0] A2_MAG = (64'd284496736 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
  localparam logic [63:0] A3_MAG = (64'd1421413741 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
  localparam logic [63:0] A4_MAG = (64'd1453152027 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
  localparam logic [63:0] A5_MAG = (64'd1061405429 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
  localparam logic [63:0] P_MAG  = (64'd327591100 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
  localparam logic [63:0] ISQ2_MAG = (64'd707106781 * 64'd1073741824 + 64'd500000000) / 64'd1000000000;
  localparam logic [63:0] L2E_MAG  = (64'd1442695041 * 64'd268435456 + 64'd500000000) / 64'd1000000000;

  localparam logic [29:0] CINVSQ2 = 30'(ISQ2_MAG);  // 1/sqrt2, Q.30
  localparam logic [28:0] CP      = 29'(P_MAG);     // p, Q.30
  localparam logic [28:0] CLOG2E  = 29'(L2E_MAG);   // log2(e), Q.28

  localparam logic signed [33:0] CA1 = 34'(A1_MAG);
  localparam logic signed [33:0] CA2 = -(34'(A2_MAG));
  localparam logic signed [33:0] CA3 = 34'(A3_MAG);
  localparam logic signed [33:0] CA4 = -(34'(A4_MAG));
  localparam logic signed [33:0] CA5 = 34'(A5_MAG);

  localparam int DIV_STAGES = 31;  // one quotient bit per stage
  localparam int HRN_STAGES = 5;
  localparam int EXP_JOIN   = 8;   // division stage that picks up exp(-u^2)

  // term added after each Horner multiply
  localparam logic signed [33:0] HORNER_ADD [HRN_STAGES] = '{CA4, CA3, CA2, CA1, 34'sd0};

  typedef struct packed {
    logic        neg;
    logic [31:0] den;
    logic [30:0] nlo;
    logic [31:0] rem;
    logic [30:0] q;
    logic [30:0] e;
  } div_t;

  typedef struct packed {
    logic               neg;
    logic [30:0]        t;
    logic [30:0]        e;
    logic signed [33:0] poly;
  } hrn_t;

  function automatic logic [63:0] umul30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + HALF_Q30) >> 30;
  endfunction

  function automatic logic [63:0] upow30(input logic [63:0] base, input logic [31:0] ex);
    logic [63:0] acc;
    logic [63:0] b;
    logic [31:0] k;
    acc = ONE_Q30;
    b   = base;
    k   = ex;
    for (int i = 0; i < 32; i++) begin
      if (k[0]) begin
        acc = umul30(acc, b);
      end
      b = umul30(b, b);
      k = k >> 1;
    end
    return acc;
  endfunction

  // largest Q.30 r with r^depth <= 0.5
  function automatic logic [63:0] pow_ratio(input logic [31:0] depth);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = HALF_Q30;
    hi = ONE_Q30;
    for (int i = 0; i < 32; i++) begin
      if (hi - lo > 64'd1) begin
        mid = lo + ((hi - lo) >> 1);
        if (upow30(mid, depth) > HALF_Q30) begin
          hi = mid;
        end else begin
          lo = mid;
        end
      end
    end
    return lo;
  endfunction

endpackage

// ----- rtl/core/normal_cdf_approx.sv -----
// normal_cdf_approx: standard normal CDF, Phi(x), one beat in per cycle unless the output stalls.
// Input stream (s_*): tdata[15:0] = x, signed Q4.12 (-8.0 .. 8.0-2^-12).
// Output stream (m_*): tdata[15:0] = Phi(x), unsigned Q0.16, 1.0 saturates
// to 65535. One output beat per input beat, in order.
// Math: Phi = 0.5*(1 + sign*erf(|x|/sqrt2)), erf by the A&S 7.1.26 rational
// form. t = 1/(1+p*u) comes from a restoring divider, one quotient bit per
// stage (31 stages); exp(-u^2) = 2^-(u^2*log2e) uses a power table with
// linear interpolation, followed by a rounding right shift.
// Stages: 4 front, 31 divider, 5 Horner and 2 output stages, in that order.
// Throughput: one beat per cycle while the output is not stalled; the divider chain sets the depth.
// Stall: the whole pipe advances as one; while the output beat is held
// (m_tvalid high, m_tready low) every stage freezes and s_tready drops.
// Beats already in flight are kept, none are lost or repeated.
// Reset: rst (synchronous, active high) clears all stage valid bits; the
// power table is a constant ROM, so no fill pass is needed.
module normal_cdf_approx #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] arg_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [15:0] probability
);
  import ncdf_pkg::*;

  localparam int IW = $clog2(EXP_TABLE_DEPTH + 1);  // table index width
  localparam int PW = 30 + IW;                      // f * depth
  localparam int NST = 4 + DIV_STAGES + HRN_STAGES + 2;

  typedef logic [EXP_TABLE_DEPTH:0][30:0] rom_t;

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] r;
    logic [63:0] acc;
    r      = pow_ratio(32'(EXP_TABLE_DEPTH));
    acc    = ONE_Q30;
    rom[0] = acc[30:0];
    for (int k = 1; k < EXP_TABLE_DEPTH; k++) begin
      acc    = umul30(acc, r);
      rom[k] = acc[30:0];
    end
    rom[EXP_TABLE_DEPTH] = HALF_Q30[30:0];
    return rom;
  endfunction

  // 2^-(k/depth), Q.30
  localparam rom_t POW_ROM = build_rom();

  // global advance: output slot empty or being taken
  logic           adv;
  logic [NST-1:0] valid;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = valid[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[NST-2:0], s_tvalid};
    end
  end

  // ---------------- front: |x|, u, p*u, u^2 ----------------
  logic        f1_neg;
  logic [15:0] f1_m;
  logic        f2_neg;
  logic [32:0] f2_u;
  logic        f3_neg;
  logic [61:0] f3_pu;
  logic [24:0] f3_uh;
  logic        f4_neg;
  logic [31:0] f4_den;
  logic [49:0] f4_uhsq;

  logic [45:0] u_prod;
  logic [32:0] u_next;
  logic [31:0] den_next;

  assign u_prod   = f1_m * CINVSQ2;
  assign u_next   = 33'((u_prod + 46'd2048) >> 12);
  assign den_next = 32'(ONE_Q30) + 32'((f3_pu + 62'(HALF_Q30)) >> 30);

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_neg  <= s_tdata[15];
      // most negative input becomes magnitude 8.0
      f1_m    <= s_tdata[15] ? 16'(17'h10000 - {1'b0, s_tdata}) : s_tdata;
      f2_neg  <= f1_neg;
      f2_u    <= u_next;
      f3_neg  <= f2_neg;
      f3_pu   <= f2_u * CP;
      f3_uh   <= 25'((f2_u + 33'd128) >> 8);
      f4_neg  <= f3_neg;
      f4_den  <= den_next;
      f4_uhsq <= f3_uh * f3_uh;
    end
  end

  // ---------------- exp(-u^2), runs beside divider stages 0..7 ----------------
  logic [35:0]    e0_u2;
  logic [46:0]    e1_plo;
  logic [46:0]    e1_phi;
  logic [5:0]     e2_n;
  logic [29:0]    e2_f;
  logic [5:0]     e3_n;
  logic [PW-1:0]  e3_pos;
  logic [5:0]     e4_n;
  logic [30:0]    e4_v0;
  logic [30:0]    e4_v1;
  logic [29:0]    e4_w;
  logic [5:0]     e5_n;
  logic [30:0]    e5_v0;
  logic [60:0]    e5_dp;
  logic [5:0]     e6_n;
  logic [30:0]    e6_v;
  logic [30:0]    e7_e;

  logic [63:0]    z_sum;
  logic [35:0]    z_val;
  logic [IW-1:0]  rom_idx;
  logic [IW-1:0]  rom_idx1;
  logic [30:0]    v_next;
  logic [40:0]    shr_sum;
  logic [40:0]    shr_val;
  logic [30:0]    e_next;

  assign z_sum    = ({17'b0, e1_phi} << 18) + {17'b0, e1_plo} + (64'd1 << 27);
  assign z_val    = z_sum[63:28];
  assign rom_idx  = e3_pos[PW-1:30];
  assign rom_idx1 = rom_idx + 1'b1;
  assign v_next   = e5_v0 - 31'((e5_dp + 61'(HALF_Q30)) >> 30);
  assign shr_sum  = {10'b0, e6_v} + (41'd1 << (e6_n - 6'd1));
  assign shr_val  = shr_sum >> e6_n;

  always_comb begin
    if (e6_n >= 6'd40) begin
      e_next = '0;  // exponent too large: exp term is zero
    end else if (e6_n == 6'd0) begin
      e_next = e6_v;
    end else begin
      e_next = shr_val[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e0_u2  <= 36'((f4_uhsq + 50'd8192) >> 14);
      // 36x29 product split in two 18-bit halves
      e1_plo <= e0_u2[17:0] * CLOG2E;
      e1_phi <= e0_u2[35:18] * CLOG2E;
      e2_n   <= z_val[35:30];
      e2_f   <= z_val[29:0];
      e3_n   <= e2_n;
      e3_pos <= e2_f * IW'(EXP_TABLE_DEPTH);
      e4_n   <= e3_n;
      e4_v0  <= POW_ROM[rom_idx];
      e4_v1  <= POW_ROM[rom_idx1];
      e4_w   <= e3_pos[29:0];
      e5_n   <= e4_n;
      e5_v0  <= e4_v0;
      e5_dp  <= (e4_v0 - e4_v1) * e4_w;
      e6_n   <= e5_n;
      e6_v   <= v_next;
      e7_e   <= e_next;
    end
  end

  // ---------------- t = round(2^60 / den), restoring divider ----------------
  div_t div_src [DIV_STAGES];
  div_t div_q   [DIV_STAGES];

  always_comb begin
    div_src[0].neg = f4_neg;
    div_src[0].den = f4_den;
    div_src[0].nlo = f4_den[31:1];      // low bits of 2^60 + den/2
    div_src[0].rem = 32'd1 << 29;       // high bits of 2^60 + den/2
    div_src[0].q   = '0;
    div_src[0].e   = '0;
    for (int j = 1; j < DIV_STAGES; j++) begin
      div_src[j] = div_q[j-1];
      if (j == EXP_JOIN) begin
        div_src[j].e = e7_e;
      end
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int QB = DIV_STAGES - 1 - j;
    logic [32:0] r2;
    logic        ge;
    div_t        nxt;

    always_comb begin
      r2  = {div_src[j].rem, div_src[j].nlo[QB]};
      ge  = r2 >= {1'b0, div_src[j].den};
      nxt = div_src[j];
      if (ge) begin
        nxt.rem   = 32'(r2 - {1'b0, div_src[j].den});
        nxt.q[QB] = 1'b1;
      end else begin
        nxt.rem = r2[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_q[j] <= nxt;
      end
    end
  end

  // ---------------- Horner polynomial in t ----------------
  hrn_t hrn_src [HRN_STAGES];
  hrn_t hrn_q   [HRN_STAGES];

  always_comb begin
    hrn_src[0].neg  = div_q[DIV_STAGES-1].neg;
    hrn_src[0].t    = div_q[DIV_STAGES-1].q;
    hrn_src[0].e    = div_q[DIV_STAGES-1].e;
    hrn_src[0].poly = CA5;
    for (int k = 1; k < HRN_STAGES; k++) begin
      hrn_src[k] = hrn_q[k-1];
    end
  end

  for (genvar k = 0; k < HRN_STAGES; k++) begin : g_hrn
    logic        sgn;
    logic [33:0] mag;
    logic [64:0] prod;
    logic [33:0] rnd;
    hrn_t        nxt;

    // magnitude rounds half up, sign restored after
    always_comb begin
      sgn      = hrn_src[k].poly[33];
      mag      = sgn ? 34'(-hrn_src[k].poly) : 34'(hrn_src[k].poly);
      prod     = {31'b0, mag} * {34'b0, hrn_src[k].t};
      rnd      = 34'((prod + 65'(HALF_Q30)) >> 30);
      nxt      = hrn_src[k];
      nxt.poly = (sgn ? -$signed(rnd) : $signed(rnd)) + HORNER_ADD[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hrn_q[k] <= nxt;
      end
    end
  end

  // ---------------- poly * exp, final sum ----------------
  logic        t1_neg;
  logic [64:0] t1_prod;
  logic [33:0] poly_pos;
  logic [34:0] term;
  logic [30:0] erf_y;
  logic [31:0] num;
  logic [16:0] num_rnd;
  logic [15:0] prob_next;
  logic [15:0] prob;

  // negative polynomial clamps to zero
  assign poly_pos = hrn_q[HRN_STAGES-1].poly[33] ? '0 : 34'(hrn_q[HRN_STAGES-1].poly);
  assign term     = 35'((t1_prod + 65'(HALF_Q30)) >> 30);
  assign erf_y    = (term > 35'(ONE_Q30)) ? '0 : 31'(35'(ONE_Q30) - term);
  assign num      = t1_neg ? 32'(ONE_Q30) - {1'b0, erf_y} : 32'(ONE_Q30) + {1'b0, erf_y};
  assign num_rnd  = 17'((num + 32'd16384) >> 15);
  assign prob_next = num_rnd[16] ? 16'hFFFF : num_rnd[15:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_neg  <= hrn_q[HRN_STAGES-1].neg;
      t1_prod <= {31'b0, poly_pos} * {34'b0, hrn_q[HRN_STAGES-1].e};
      prob    <= prob_next;
    end
  end

  assign m_tdata = prob;

`ifndef SYNTHESIS
  a_rst_empty: assert property (@(posedge clk) rst |=> (valid == '0))
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(valid))
    else $error("pipeline moved during output stall");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    valid[4 + DIV_STAGES - 1] |-> (div_q[DIV_STAGES-1].rem < div_q[DIV_STAGES-1].den))
    else $error("divider remainder out of range");
`endif

endmodule

// ----- bench/tb_normal_cdf_approx.sv -----
module tb_normal_cdf_approx;
  import ncdf_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int PIPE_LATENCY = 42;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [15:0] arg_value
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [15:0] probability

  normal_cdf_approx #(.EXP_TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // idle/stall percentages for the sender and the receiver
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;      // forced receiver hold-off, counted down
  int unsigned error_count;
  logic [15:0] phi_expected[$];

  // power-of-two table, Q2.30: 2^-(k/TABLE_DEPTH)
  logic [63:0] pow2_table [0:TABLE_DEPTH];

  function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] pow_q30(logic [63:0] base, int unsigned ex);
    logic [63:0] acc;
    acc = 64'd1 << 30;
    while (ex != 0) begin
      if (ex[0]) acc = mul_q30(acc, base);
      base = mul_q30(base, base);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  task automatic build_pow2_table();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd1 << 29;
    hi = 64'd1 << 30;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      if (pow_q30(mid, TABLE_DEPTH) > (64'd1 << 29)) hi = mid;
      else lo = mid;
    end
    pow2_table[0] = 64'd1 << 30;
    for (int k = 1; k < TABLE_DEPTH; k++) pow2_table[k] = mul_q30(pow2_table[k-1], lo);
    pow2_table[TABLE_DEPTH] = 64'd1 << 29;
  endtask

  // sign-magnitude Q.30 product
  function automatic longint smul_q30(longint a, logic [63:0] t);
    logic [63:0] p;
    p = mul_q30((a < 0) ? 64'(-a) : 64'(a), t);
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  // exp(-u^2), u in Q.30
  function automatic logic [63:0] gauss_decay(logic [63:0] u);
    logic [63:0] uh, u2, z, n, f, pos, idx, w, v0, v1, v;
    uh  = (u + 128) >> 8;
    u2  = (uh * uh + 8192) >> 14;
    z   = (u2 * 64'(CLOG2E) + (64'd1 << 27)) >> 28;
    n   = z >> 30;
    f   = z & ((64'd1 << 30) - 1);
    pos = f * TABLE_DEPTH;
    idx = pos >> 30;
    w   = pos & ((64'd1 << 30) - 1);
    if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
    v0 = pow2_table[idx];
    v1 = pow2_table[idx + 1];
    v  = v0 - (((v0 - v1) * w + (64'd1 << 29)) >> 30);
    if (n >= 40) return 64'd0;
    if (n == 0) return v;
    return (v + (64'd1 << (n - 1))) >> n;
  endfunction

  function automatic logic [15:0] normal_cdf(logic [15:0] x);
    logic        neg;
    logic [63:0] m, u, den, t, e, term, y, num;
    longint      poly;
    neg  = x[15];
    m    = neg ? (64'h10000 - 64'(x)) : 64'(x);
    u    = (m * 64'(CINVSQ2) + 2048) >> 12;
    den  = (64'd1 << 30) + mul_q30(64'(CP), u);
    t    = ((64'd1 << 60) + (den >> 1)) / den;
    poly = longint'(CA5);
    poly = smul_q30(poly, t) + longint'(CA4);
    poly = smul_q30(poly, t) + longint'(CA3);
    poly = smul_q30(poly, t) + longint'(CA2);
    poly = smul_q30(poly, t) + longint'(CA1);
    poly = smul_q30(poly, t);
    if (poly < 0) poly = 0;   // negative polynomial clamps to zero
    e    = gauss_decay(u);
    term = mul_q30(64'(poly), e);
    y    = (term > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - term;
    num  = neg ? ((64'd1 << 30) - y) : ((64'd1 << 30) + y);
    num  = (num + 16384) >> 15;
    if (num > 65535) num = 65535;   // 1.0 saturates
    return num[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // send one argument beat; random idle cycles before it.
  // valid stays high after the beat; the next idle cycle or drain drops it
  task automatic send_arg(logic [15:0] x);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    phi_expected.push_back(normal_cdf(x));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (phi_expected.size() != 0) @(posedge clk);
  endtask

  // receiver ready: random stalls plus forced hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (phi_expected.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata, 16'd0);
      end else begin
        if (m_tdata !== phi_expected[0])
          report_mismatch("probability", m_tdata, phi_expected[0]);
        void'(phi_expected.pop_front());
      end
    end
  end

  task automatic test_directed();
    logic [15:0] pts[$];
    pts = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
            16'h1000, 16'hF000, 16'h2000, 16'hE000, 16'h4000, 16'hC000,
            16'h5555, 16'hAAAA, 16'h0800, 16'hF800, 16'h3000, 16'hD000,
            16'h6000, 16'hA000, 16'h00FF, 16'hFF00};
    foreach (pts[i]) send_arg(pts[i]);
    drain();
  endtask

  // mostly the interesting region |x| < 5, some full-range values
  task automatic test_random(int unsigned count);
    logic [15:0] x;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3, 0) == 0) x = 16'($urandom);
      else x = 16'($signed($urandom_range(40000, 0)) - 20000);
      send_arg(x);
    end
  endtask

  // receiver holds off long enough that the pipe fills and s_tready drops
  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_cycles <= 200;
    test_random(228);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 16'd0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    error_count = 0;
    build_pow2_table();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(400);
    send_idle_pct = 82; recv_stall_pct = 0;  test_random(300);
    drain();   // sender pauses until all results are back
    send_idle_pct = 0;  recv_stall_pct = 82; test_random(350);
    send_idle_pct = 10; recv_stall_pct = 10; test_random(350);
    recv_stall_pct = 0;
    test_backpressure();

    drain();
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("normal_cdf_approx test passed");
    end else begin
      $display("normal_cdf_approx test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("normal_cdf_approx test failed");
    $finish;
  end

endmodule
